// ===== rtl/krt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krt_pkg: shared types and codes for the keyed record table
// Opcodes, status codes, result kinds and the controller/datapath structs.
// ----------------------------------------------------------------------------
package krt_pkg;

  // default sizing
  localparam int DEF_TABLE_DEPTH  = 16;
  localparam int DEF_PAYLOAD_BITS = 64;

  // field widths of the request and response beats
  localparam int OPCODE_W = 3;
  localparam int ID_W     = 16;
  localparam int INDEX_W  = 4;
  localparam int DATA_W   = 64;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // request opcodes
  localparam logic [OPCODE_W-1:0] OP_ADD    = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_EDIT   = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_REMOVE = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_FIND   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_READ   = 3'd4;

  // response status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISSING   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd3;

  // what the output register is loaded with
  typedef enum logic [2:0] {
    RES_OK_ADD  = 3'd0,
    RES_FULL    = 3'd1,
    RES_EXH     = 3'd2,
    RES_MISS    = 3'd3,
    RES_OK_KEY  = 3'd4,
    RES_OK_FIND = 3'd5,
    RES_OK_READ = 3'd6
  } krt_res_t;

  // commands from controller to datapath
  typedef struct packed {
    logic     load;         // capture request fields, restart scan
    logic     scan;         // advance the id search one entry
    logic     start_shift;  // set up compaction after the hit
    logic     shift;        // advance compaction one entry
    logic     add;          // append a record
    logic     edit;         // rewrite payload at the hit
    logic     shrink;       // drop one from the count
    logic     rd_pos;       // read the entry at the requested position
    logic     set_res;      // load the output register
    krt_res_t res;
  } krt_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic full;
    logic exhausted;
    logic pos_ok;
    logic hit;
    logic miss;
    logic shift_done;
    logic out_free;
  } krt_sts_t;

endpackage

// ===== rtl/krt_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krt_req_if: request channel of the keyed record table
// Valid/ready handshake carrying one request beat.
// ----------------------------------------------------------------------------
interface krt_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [15:0] key_id;
  logic [3:0]  entry_index;
  logic [63:0] record_data;

  modport source (output valid, output opcode, output key_id, output entry_index,
                  output record_data, input ready);
  modport sink (input valid, input opcode, input key_id, input entry_index,
                input record_data, output ready);
endinterface

// ===== rtl/krt_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krt_rsp_if: response channel of the keyed record table
// Valid/ready handshake carrying one result beat.
// ----------------------------------------------------------------------------
interface krt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] record_id;
  logic [63:0] record_out;
  logic [4:0]  entry_count;

  modport source (output valid, output status, output record_id, output record_out,
                  output entry_count, input ready);
  modport sink (input valid, input status, input record_id, input record_out,
                input entry_count, output ready);
endinterface

// ===== rtl/krt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krt_ctrl: request sequencer of the keyed record table
// One-hot state machine that steps the datapath through each operation.
// ----------------------------------------------------------------------------
module krt_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic [krt_pkg::OPCODE_W-1:0]   opcode,
  output logic                           in_ready,
  input  krt_pkg::krt_sts_t              sts,
  output krt_pkg::krt_cmd_t              cmd
);
  import krt_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_ADD    = 7'b0000010,
    S_SCAN   = 7'b0000100,
    S_SHIFT  = 7'b0001000,
    S_RDAT   = 7'b0010000,
    S_RDWAIT = 7'b0100000,
    S_BAD    = 7'b1000000
  } state_t;

  state_t              state, state_next;
  logic [OPCODE_W-1:0] op;

  // state and opcode registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_ADD;
    end else begin
      state <= state_next;
      if (in_valid && in_ready) op <= opcode;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.res    = RES_MISS;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (opcode) inside
            OP_ADD:                     state_next = S_ADD;
            OP_EDIT, OP_REMOVE, OP_FIND: state_next = S_SCAN;
            OP_READ:                    state_next = S_RDAT;
            default:                    state_next = S_BAD;
          endcase
        end
      end
      S_ADD: begin
        if (sts.out_free) begin
          cmd.set_res = 1'b1;
          if (sts.full) begin
            cmd.res = RES_FULL;
          end else if (sts.exhausted) begin
            cmd.res = RES_EXH;
          end else begin
            cmd.add = 1'b1;
            cmd.res = RES_OK_ADD;
          end
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        if (sts.hit) begin
          if (op == OP_REMOVE) begin
            cmd.start_shift = 1'b1;
            state_next      = S_SHIFT;
          end else if (sts.out_free) begin
            cmd.set_res = 1'b1;
            if (op == OP_EDIT) begin
              cmd.edit = 1'b1;
              cmd.res  = RES_OK_KEY;
            end else begin
              cmd.res = RES_OK_FIND;
            end
            state_next = S_IDLE;
          end
        end else if (sts.miss) begin
          if (sts.out_free) begin
            cmd.set_res = 1'b1;
            cmd.res     = RES_MISS;
            state_next  = S_IDLE;
          end
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_SHIFT: begin
        if (sts.shift_done) begin
          if (sts.out_free) begin
            cmd.shrink  = 1'b1;
            cmd.set_res = 1'b1;
            cmd.res     = RES_OK_KEY;
            state_next  = S_IDLE;
          end
        end else begin
          cmd.shift = 1'b1;
        end
      end
      S_RDAT: begin
        if (sts.pos_ok) begin
          cmd.rd_pos = 1'b1;
          state_next = S_RDWAIT;
        end else if (sts.out_free) begin
          cmd.set_res = 1'b1;
          cmd.res     = RES_MISS;
          state_next  = S_IDLE;
        end
      end
      S_RDWAIT: begin
        if (sts.out_free) begin
          cmd.set_res = 1'b1;
          cmd.res     = RES_OK_READ;
          state_next  = S_IDLE;
        end
      end
      S_BAD: begin
        if (sts.out_free) begin
          cmd.set_res = 1'b1;
          cmd.res     = RES_MISS;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/krt_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krt_datapath: storage and arithmetic of the keyed record table
// Id and payload memories, count and id counter, scan and compaction
// pointers, and the response register.
// ----------------------------------------------------------------------------
module krt_datapath #(
  parameter int TABLE_DEPTH  = krt_pkg::DEF_TABLE_DEPTH,
  parameter int PAYLOAD_BITS = krt_pkg::DEF_PAYLOAD_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [krt_pkg::ID_W-1:0]      key_id,
  input  logic [krt_pkg::INDEX_W-1:0]   entry_index,
  input  logic [krt_pkg::DATA_W-1:0]    record_data,
  input  krt_pkg::krt_cmd_t             cmd,
  output krt_pkg::krt_sts_t             sts,
  krt_rsp_if.source                     rsp
);
  import krt_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;

  // record storage
  logic [ID_W-1:0]         ids [TABLE_DEPTH];
  logic [PAYLOAD_BITS-1:0] pls [TABLE_DEPTH];

  logic [CW-1:0]           count, count_next;
  logic [ID_W-1:0]         next_id;
  logic [ID_W-1:0]         key;
  logic [INDEX_W-1:0]      pos;
  logic [PAYLOAD_BITS-1:0] data;
  logic [CW-1:0]           ptr;
  logic                    cmp_v;
  logic [AW-1:0]           cmp_pos;
  logic                    sh_v;
  logic [AW-1:0]           sh_addr;
  logic [ID_W-1:0]         id_q;
  logic [PAYLOAD_BITS-1:0] pl_q;

  logic                    rd_en;
  logic [AW-1:0]           rd_addr;
  logic                    id_we, pl_we;
  logic [AW-1:0]           wr_addr;
  logic [ID_W-1:0]         wr_id;
  logic [PAYLOAD_BITS-1:0] wr_pl;
  logic                    ptr_live;

  logic                    out_v;
  logic [STATUS_W-1:0]     out_status;
  logic [ID_W-1:0]         out_rid;
  logic [DATA_W-1:0]       out_rout;
  logic [COUNT_W-1:0]      out_cnt;

  assign ptr_live = (ptr < count);

  // status to the controller
  always_comb begin
    sts.full       = (count == CW'(TABLE_DEPTH));
    sts.exhausted  = (next_id == '0);
    sts.pos_ok     = (XW'(pos) < XW'(count));
    sts.hit        = cmp_v && (id_q == key) && (key != '0);
    sts.miss       = !cmp_v && !ptr_live;
    sts.shift_done = !sh_v && !ptr_live;
    sts.out_free   = !out_v || rsp.ready;
  end

  // memory port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ptr[AW-1:0];
    id_we   = 1'b0;
    pl_we   = 1'b0;
    wr_addr = sh_addr;
    wr_id   = id_q;
    wr_pl   = pl_q;
    if ((cmd.scan || cmd.shift) && ptr_live) rd_en = 1'b1;
    if (cmd.rd_pos) begin
      rd_en   = 1'b1;
      rd_addr = AW'(XW'(pos));
    end
    if (cmd.shift && sh_v) begin
      id_we = 1'b1;
      pl_we = 1'b1;
    end
    if (cmd.add) begin
      id_we   = 1'b1;
      pl_we   = 1'b1;
      wr_addr = count[AW-1:0];
      wr_id   = next_id;
      wr_pl   = data;
    end
    if (cmd.edit) begin
      pl_we   = 1'b1;
      wr_addr = cmp_pos;
      wr_pl   = data;
    end
  end

  // memories with registered read
  always_ff @(posedge clk) begin
    if (id_we) ids[wr_addr] <= wr_id;
    if (pl_we) pls[wr_addr] <= wr_pl;
    if (rd_en) begin
      id_q <= ids[rd_addr];
      pl_q <= pls[rd_addr];
    end
  end

  // count after this cycle
  always_comb begin
    count_next = count;
    if (cmd.add)         count_next = count + CW'(1);
    else if (cmd.shrink) count_next = count - CW'(1);
  end

  // table state
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      next_id <= ID_W'(1);
    end else begin
      count <= count_next;
      if (cmd.add) next_id <= next_id + ID_W'(1);
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key  <= key_id;
      pos  <= entry_index;
      data <= record_data[PAYLOAD_BITS-1:0];
    end
  end

  // scan and compaction pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr   <= '0;
      cmp_v <= 1'b0;
      sh_v  <= 1'b0;
    end else if (cmd.load) begin
      ptr   <= '0;
      cmp_v <= 1'b0;
      sh_v  <= 1'b0;
    end else if (cmd.scan) begin
      cmp_v <= ptr_live;
      if (ptr_live) begin
        cmp_pos <= ptr[AW-1:0];
        ptr     <= ptr + CW'(1);
      end
    end else if (cmd.start_shift) begin
      ptr  <= CW'(cmp_pos) + CW'(1);
      sh_v <= 1'b0;
    end else if (cmd.shift) begin
      sh_v <= ptr_live;
      if (ptr_live) begin
        sh_addr <= AW'(ptr - CW'(1));
        ptr     <= ptr + CW'(1);
      end
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (cmd.set_res) begin
      out_v <= 1'b1;
    end else if (rsp.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      out_cnt <= COUNT_W'(count_next);
      unique case (cmd.res)
        RES_OK_ADD: begin
          out_status <= ST_OK;
          out_rid    <= next_id;
          out_rout   <= '0;
        end
        RES_FULL: begin
          out_status <= ST_FULL;
          out_rid    <= '0;
          out_rout   <= '0;
        end
        RES_EXH: begin
          out_status <= ST_EXHAUSTED;
          out_rid    <= '0;
          out_rout   <= '0;
        end
        RES_OK_KEY: begin
          out_status <= ST_OK;
          out_rid    <= key;
          out_rout   <= '0;
        end
        RES_OK_FIND: begin
          out_status <= ST_OK;
          out_rid    <= key;
          out_rout   <= DATA_W'(pl_q);
        end
        RES_OK_READ: begin
          out_status <= ST_OK;
          out_rid    <= id_q;
          out_rout   <= DATA_W'(pl_q);
        end
        default: begin
          out_status <= ST_MISSING;
          out_rid    <= '0;
          out_rout   <= '0;
        end
      endcase
    end
  end

  assign rsp.valid       = out_v;
  assign rsp.status      = out_status;
  assign rsp.record_id   = out_rid;
  assign rsp.record_out  = out_rout;
  assign rsp.entry_count = out_cnt;

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.add |=> count == CW'($past(count) + CW'(1)))
    else $error("add did not grow the count by one");

  a_shrink_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.shrink |-> count != '0)
    else $error("remove committed on an empty table");

  a_shift_in_range: assert property (@(posedge clk) disable iff (rst)
    sh_v |-> CW'(sh_addr) < count)
    else $error("compaction write outside stored entries");

endmodule

// ===== rtl/keyed_record_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_record_table: packed record table with self-assigned identifiers
// Add, edit, remove with compaction, find by id and read by position.
// The id search and the compaction walk one memory entry per cycle through a
// single read port.
// One request is in flight at a time; the next beat is taken while the result
// waits. Reset clears count and sets the next id to one; no memory clear pass.
// ----------------------------------------------------------------------------
module keyed_record_table #(
  parameter int TABLE_DEPTH  = krt_pkg::DEF_TABLE_DEPTH,
  parameter int PAYLOAD_BITS = krt_pkg::DEF_PAYLOAD_BITS
) (
  input  logic      clk,
  input  logic      rst,
  krt_req_if.sink   req,
  krt_rsp_if.source rsp
);
  import krt_pkg::*;

  krt_cmd_t cmd;
  krt_sts_t sts;
  logic     in_ready;

  assign req.ready = in_ready;

  // sequencer
  krt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .opcode   (req.opcode),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // storage and result path
  krt_datapath #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .key_id      (req.key_id),
    .entry_index (req.entry_index),
    .record_data (req.record_data),
    .cmd         (cmd),
    .sts         (sts),
    .rsp         (rsp)
  );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for keyed_record_table
// Drives add, edit, remove, find and read-at requests over the request channel
// and keeps a shadow copy of the packed table. Every response beat is checked
// field by field against the shadow prediction. Covers an empty and a full
// table, misses, bad positions, spare opcodes and back-pressure, with random
// idling on both channels.
// ----------------------------------------------------------------------------
module tb;
  import krt_pkg::*;

  localparam int DEPTH = DEF_TABLE_DEPTH;
  localparam int PBITS = DEF_PAYLOAD_BITS;
  localparam logic [DATA_W-1:0] PAYLOAD_MASK = {DATA_W{1'b1}} >> (DATA_W - PBITS);
  localparam logic [OPCODE_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_SPARE_LAST  = 3'd7;
  localparam logic [ID_W-1:0] ID_LAST = {ID_W{1'b1}};
  localparam int MAX_REPORTS   = 10;
  localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
  localparam int HOLD_CYCLES   = 400;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     id;
    logic [DATA_W-1:0]   payload;
    logic [COUNT_W-1:0]  count;
  } table_result_t;

  logic clk;
  logic rst;

  krt_req_if req_bus ();
  krt_rsp_if rsp_bus ();

  keyed_record_table uut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  // shadow copy of the table
  logic [ID_W-1:0]   shadow_ids      [DEPTH];
  logic [DATA_W-1:0] shadow_payloads [DEPTH];
  int                shadow_count;
  logic [ID_W-1:0]   shadow_next_id;
  logic [ID_W-1:0]   last_removed_id;

  table_result_t pending_results [$];
  int error_count;
  int send_idle_pct;
  int recv_idle_pct;
  int recv_hold_cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard limit on run time
  initial begin
    #50_000_000;
    $display("keyed_record_table test failed");
    $finish;
  end

  // position of a stored id, -1 when absent
  function automatic int find_position(input logic [ID_W-1:0] key);
    if (key == '0) return -1;
    for (int i = 0; i < shadow_count; i++)
      if (shadow_ids[i] == key) return i;
    return -1;
  endfunction

  // apply one request to the shadow table and return its response
  function automatic table_result_t table_step(input logic [OPCODE_W-1:0] op,
                                               input logic [ID_W-1:0] key,
                                               input logic [INDEX_W-1:0] idx,
                                               input logic [DATA_W-1:0] data_in);
    table_result_t r;
    logic [DATA_W-1:0] data;
    int at;
    data      = data_in & PAYLOAD_MASK;
    r.status  = ST_MISSING;
    r.id      = '0;
    r.payload = '0;
    case (op)
      OP_ADD: begin
        if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
        end else if (shadow_next_id == '0) begin
          r.status = ST_EXHAUSTED;
        end else begin
          r.id = shadow_next_id;
          shadow_ids[shadow_count]      = shadow_next_id;
          shadow_payloads[shadow_count] = data;
          shadow_count++;
          shadow_next_id = shadow_next_id + 1'b1;
          r.status = ST_OK;
        end
      end
      OP_EDIT: begin
        at = find_position(key);
        if (at >= 0) begin
          shadow_payloads[at] = data;
          r.id = key;
          r.status = ST_OK;
        end
      end
      OP_REMOVE: begin
        at = find_position(key);
        if (at >= 0) begin
          for (int j = at; j + 1 < shadow_count; j++) begin
            shadow_ids[j]      = shadow_ids[j + 1];
            shadow_payloads[j] = shadow_payloads[j + 1];
          end
          shadow_count--;
          last_removed_id = key;
          r.id = key;
          r.status = ST_OK;
        end
      end
      OP_FIND: begin
        at = find_position(key);
        if (at >= 0) begin
          r.id = key;
          r.payload = shadow_payloads[at];
          r.status = ST_OK;
        end
      end
      OP_READ: begin
        if (int'(idx) < shadow_count) begin
          r.id = shadow_ids[idx];
          r.payload = shadow_payloads[idx];
          r.status = ST_OK;
        end
      end
      default: ;
    endcase
    r.count = shadow_count[COUNT_W-1:0];
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] random_payload();
    return {$urandom, $urandom};
  endfunction

  // mostly ids that hit, some stale, zero or arbitrary ones
  function automatic logic [ID_W-1:0] pick_key();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60 && shadow_count > 0) return shadow_ids[$urandom_range(shadow_count - 1)];
    if (roll < 75) return last_removed_id;
    if (roll < 85) return '0;
    return ID_W'($urandom);
  endfunction

  function automatic logic [INDEX_W-1:0] pick_index();
    if ($urandom_range(99) < 70 && shadow_count > 0)
      return INDEX_W'($urandom_range(shadow_count - 1));
    return INDEX_W'($urandom);
  endfunction

  // response side: random idling or a long hold-off
  always @(negedge clk) begin
    if (recv_hold_cycles > 0) begin
      rsp_bus.ready = 1'b0;
      recv_hold_cycles = recv_hold_cycles - 1;
    end else begin
      rsp_bus.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare each response beat with the oldest prediction
  always @(posedge clk) begin : check_results
    table_result_t expected_result;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: response beat with nothing outstanding: status %0d id %h data %h count %0d",
                   $realtime, rsp_bus.status, rsp_bus.record_id, rsp_bus.record_out,
                   rsp_bus.entry_count);
      end else begin
        expected_result = pending_results.pop_front();
        if (rsp_bus.status !== expected_result.status ||
            rsp_bus.record_id !== expected_result.id ||
            rsp_bus.record_out !== expected_result.payload ||
            rsp_bus.entry_count !== expected_result.count) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: mismatch: expected status %0d id %h data %h count %0d, got status %0d id %h data %h count %0d",
                     $realtime, expected_result.status, expected_result.id,
                     expected_result.payload, expected_result.count, rsp_bus.status,
                     rsp_bus.record_id, rsp_bus.record_out, rsp_bus.entry_count);
        end
      end
    end
  end

  // offer one request beat and predict its response once it is taken
  task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [ID_W-1:0] key,
                              input logic [INDEX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(negedge clk);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      req_bus.valid = 1'b0;
      @(negedge clk);
    end
    req_bus.valid       = 1'b1;
    req_bus.opcode      = op;
    req_bus.key_id      = key;
    req_bus.entry_index = idx;
    req_bus.record_data = data;
    do @(posedge clk); while (!req_bus.ready);
    pending_results.push_back(table_step(op, key, idx, data));
  endtask

  // stop offering and wait for every outstanding response
  task automatic end_requests();
    @(negedge clk);
    req_bus.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // empty table
    send_request(OP_READ, '0, '0, '0);
    send_request(OP_EDIT, '0, '0, '1);
    send_request(OP_SPARE_FIRST, 16'd1, 4'd0, '1);
    send_request(OP_SPARE_LAST, ID_LAST, '1, '1);
    // fill to the brim, then one more add
    send_request(OP_ADD, ID_LAST, '1, '1);
    send_request(OP_ADD, '0, '0, '0);
    repeat (DEPTH - 2) send_request(OP_ADD, '0, '0, random_payload());
    send_request(OP_ADD, '0, '0, random_payload());
    // hits at both ends of the table
    send_request(OP_FIND, 16'd1, '0, '0);
    send_request(OP_EDIT, 16'd2, '0, '1);
    send_request(OP_READ, '0, '1, '0);
    send_request(OP_REMOVE, 16'd1, '0, '0);
    send_request(OP_READ, '0, '1, '0);
    send_request(OP_READ, '0, 4'(DEPTH - 2), '0);
    send_request(OP_FIND, 16'd1, '0, '0);
    end_requests();
  endtask

  task automatic test_random(input int items, input int send_pct, input int recv_pct);
    int roll;
    int add_top, edit_top, remove_top, find_top;
    logic [OPCODE_W-1:0] op;
    logic shrink_bias;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    shrink_bias   = 1'b0;
    for (int i = 0; i < items; i++) begin
      // swing between growing and draining the table
      if (i % 64 == 0) shrink_bias = 1'($urandom_range(1));
      add_top    = shrink_bias ? 10 : 35;
      edit_top   = add_top + 15;
      remove_top = edit_top + (shrink_bias ? 40 : 15);
      find_top   = remove_top + (95 - remove_top) / 2;
      roll = $urandom_range(99);
      if (roll < add_top)         op = OP_ADD;
      else if (roll < edit_top)   op = OP_EDIT;
      else if (roll < remove_top) op = OP_REMOVE;
      else if (roll < find_top)   op = OP_FIND;
      else if (roll < 95)         op = OP_READ;
      else                        op = OPCODE_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      send_request(op, pick_key(), pick_index(), random_payload());
    end
    end_requests();
  endtask

  // response side holds off while requests keep coming
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(negedge clk);
    recv_hold_cycles = HOLD_CYCLES;
    repeat (12) send_request($urandom_range(1) ? OP_FIND : OP_READ, pick_key(), pick_index(),
                             random_payload());
    end_requests();
  endtask

  initial begin
    rst                 = 1'b1;
    req_bus.valid       = 1'b0;
    req_bus.opcode      = '0;
    req_bus.key_id      = '0;
    req_bus.entry_index = '0;
    req_bus.record_data = '0;
    rsp_bus.ready       = 1'b0;
    error_count         = 0;
    send_idle_pct       = 0;
    recv_idle_pct       = 0;
    recv_hold_cycles    = 0;
    shadow_count        = 0;
    shadow_next_id      = 16'd1;
    last_removed_id     = '0;
    for (int i = 0; i < DEPTH; i++) begin
      shadow_ids[i]      = '0;
      shadow_payloads[i] = '0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random(700, 33, 57);
    test_backpressure();
    test_random(650, 57, 33);
    test_random(650, 0, 0);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("keyed_record_table test passed");
    end else begin
      $display("keyed_record_table test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/krt_pkg.sv
rtl/krt_req_if.sv
rtl/krt_rsp_if.sv
rtl/krt_ctrl.sv
rtl/krt_datapath.sv
rtl/keyed_record_table.sv
tb/sv/tb.sv
